@@ rtl/rgb_3x3_kernel_filter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// rgb 3x3 kernel filter unit - assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_KERNEL_FILTER_UNIT_MACROS_SVH
`define RGB_3X3_KERNEL_FILTER_UNIT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define RGBKF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("rgbkf assertion failed");

// next-cycle implication, quiet while reset is asserted
`define RGBKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("rgbkf assertion failed");

`endif

@@ rtl/rgbkf_pkg.sv @@
// ----------------------------------------------------------------------------
// rgb 3x3 kernel filter package
// shared widths, register indexes, filter codes and pixel type
// ----------------------------------------------------------------------------
package rgbkf_pkg;

	localparam int CHANNELS   = 3;
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 16;
	localparam int FW_W       = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_LEFT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_TOP      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_RIGHT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_BOTTOM   = 3'd7;

	// filter codes
	localparam logic [1:0] MODE_EDGE    = 2'd0;
	localparam logic [1:0] MODE_SHARPEN = 2'd1;
	localparam logic [1:0] MODE_BOX     = 2'd2;
	localparam logic [1:0] MODE_GAUSS   = 2'd3;

	// index 0 is red, 1 green, 2 blue
	typedef logic [CHANNELS-1:0][PIX_W-1:0] pix_t;

endpackage

@@ rtl/rgbkf_ram.sv @@
// ----------------------------------------------------------------------------
// rgbkf generic ram
// one write port, one read port, registered read data, read-before-write
// ----------------------------------------------------------------------------
module rgbkf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/rgb_3x3_kernel_filter_unit.sv @@
// ----------------------------------------------------------------------------
// rgb 3x3 kernel filter unit
// raster rgb stream through two line buffers and a 3x3 window, one kernel
// per channel, border and out-of-selection pixels passed through
// ----------------------------------------------------------------------------
// usage
// - pixels enter in raster order on in_valid/in_stall; each result leaves
//   on out_valid/out_stall with its row and column
// - a pixel (r,c) leaves when pixel (r+1,c+1) arrives; on the last row
//   pixels leave as they arrive, the last column of a row leaves with it
// - one input transaction per clock while each pixel causes one result and
//   out_stall is low; a pixel that causes two or three results (end of row,
//   last row) holds the input while stage 2 passes them to the output register
// - a result passes stage 1 (line buffer read and window sums), stage 2
//   (kernel) and the output register before it shows on out_valid
// - the line buffers are one ram, one read and one write per cycle; a read
//   of the entry being written in the same cycle is forwarded
// - step_end marks the last result of a transaction, frame_end the final
//   pixel of the frame
// - reset clears the position counters, the window and the pipeline and
//   loads the register defaults; line buffer contents are not cleared
// - out_stall holds the output register, backing the pipeline up to in_stall;
//   the user writes configuration via cfg_write, unenforced, only while idle
// ----------------------------------------------------------------------------
module rgb_3x3_kernel_filter_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rgbkf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgbkf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rgbkf_pkg::PIX_W-1:0]         in_red,
	input  logic [rgbkf_pkg::PIX_W-1:0]         in_green,
	input  logic [rgbkf_pkg::PIX_W-1:0]         in_blue,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rgbkf_pkg::ROW_W-1:0]         out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
	output logic [rgbkf_pkg::PIX_W-1:0]         out_red,
	output logic [rgbkf_pkg::PIX_W-1:0]         out_green,
	output logic [rgbkf_pkg::PIX_W-1:0]         out_blue,
	output logic                                step_end,
	output logic                                frame_end
);

	import rgbkf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
	localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
	localparam int LB_W = 2 * CHANNELS * PIX_W;
	// floor(n/9) = (n * 7282) >> 16 for n below 2300
	localparam logic [12:0] BOX_RECIP = 13'd7282;

	// ---------------- configuration ----------------
	logic [1:0]       mode_q;
	logic [PIX_W-1:0] max_q;
	logic [FW_W-1:0]  fw_q, sl_q, sr_q;
	logic [ROW_W-1:0] fh_q, st_q, sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EDGE;
			max_q  <= 8'd255;
			fw_q   <= 11'd1024;
			fh_q   <= 16'd1;
			sl_q   <= 11'd0;
			st_q   <= 16'd0;
			sr_q   <= 11'd1024;
			sb_q   <= 16'hFFFF;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FILTER_MODE:  mode_q <= cfg_data[1:0];
				REG_MAX_LEVEL:    max_q  <= cfg_data[PIX_W-1:0];
				REG_FRAME_WIDTH:  fw_q   <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q   <= cfg_data[ROW_W-1:0];
				REG_SEL_LEFT:     sl_q   <= cfg_data[FW_W-1:0];
				REG_SEL_TOP:      st_q   <= cfg_data[ROW_W-1:0];
				REG_SEL_RIGHT:    sr_q   <= cfg_data[FW_W-1:0];
				REG_SEL_BOTTOM:   sb_q   <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;

	always_comb begin
		if (fw_q == '0) begin
			w_eff = WW'(1);
		end else if (WW'(fw_q) > MAXW) begin
			w_eff = MAXW;
		end else begin
			w_eff = WW'(fw_q);
		end
		h_eff = (fh_q == '0) ? 16'd1 : fh_q;
	end

	// ---------------- handshake ----------------
	logic in_acc, s1_adv, s2_free, out_rdy, issue;
	logic s1_valid, s2_valid;

	assign in_acc  = in_valid && !in_stall;
	assign in_stall = s1_valid && !s1_adv;
	assign out_rdy = !out_valid || !out_stall;

	// ---------------- position counters ----------------
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic [WW-1:0]    c_p1;
	logic [ROW_W:0]   r_p1;
	logic             last_col, last_row;

	assign c_p1     = WW'(col_q) + WW'(1);
	assign r_p1     = {1'b0, row_q} + 17'd1;
	assign last_col = c_p1 >= w_eff;
	assign last_row = r_p1 >= {1'b0, h_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_p1[ROW_W-1:0];
			end else begin
				col_q <= c_p1[CW-1:0];
			end
		end
	end

	// ---------------- line buffers ----------------
	pix_t            px_s1, up, mid;
	logic [CW-1:0]   col_s1;
	logic [LB_W-1:0] rd_data, wr_data;
	logic            fwd_s1;
	logic [LB_W-1:0] fwd_data_s1;

	// older line in the upper half, newer line in the lower half
	assign wr_data = {mid, px_s1};

	rgbkf_ram #(
		.WIDTH(LB_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (s1_adv),
		.wr_addr(col_s1),
		.wr_data(wr_data),
		.rd_en  (in_acc),
		.rd_addr(col_q),
		.rd_data(rd_data)
	);

	// ---------------- stage 1: window and sums ----------------
	logic [ROW_W-1:0] row_s1;
	logic             last_col_s1, last_row_s1;
	pix_t             win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= 1'b1;
			// same entry written as this read: ram returns old data
			fwd_s1   <= s1_adv && (col_s1 == col_q);
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1       <= {in_blue, in_green, in_red};
			row_s1      <= row_q;
			col_s1      <= col_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			fwd_data_s1 <= wr_data;
		end
	end

	assign {up, mid} = fwd_s1 ? fwd_data_s1 : rd_data;

	logic [2:0]       emit_s1;
	logic             filt_s1;
	logic [WW-1:0]    x_s1;
	logic [ROW_W-1:0] y_s1;
	logic [CHANNELS-1:0][9:0] cross_s1, corner_s1;

	always_comb begin
		x_s1 = WW'(col_s1) - WW'(1);
		y_s1 = row_s1 - 16'd1;
		emit_s1[0] = (row_s1 != '0) && (col_s1 != '0);
		emit_s1[1] = (row_s1 != '0) && last_col_s1;
		emit_s1[2] = last_row_s1;
		filt_s1 = (row_s1 >= 16'd2) && (col_s1 >= CW'(2)) &&
			(row_s1 < h_eff) && (WW'(col_s1) < w_eff) &&
			(x_s1 >= WW'(sl_q)) && (x_s1 < WW'(sr_q)) &&
			(y_s1 >= st_q) && (y_s1 < sb_q);
		for (int k = 0; k < CHANNELS; k++) begin
			cross_s1[k] = 10'(win_q[3][k]) + 10'(win_q[1][k]) +
				10'(mid[k]) + 10'(win_q[5][k]);
			corner_s1[k] = 10'(win_q[0][k]) + 10'(up[k]) +
				10'(win_q[2][k]) + 10'(px_s1[k]);
		end
	end

	assign s1_adv = s1_valid && ((emit_s1 == '0) || s2_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up;
			win_q[4] <= mid;
			win_q[5] <= px_s1;
		end
	end

	// ---------------- stage 2: kernel and result sequencing ----------------
	logic [2:0]       pend_s2;
	logic             filt_s2, last_col_s2;
	pix_t             centre_s2, mid_s2, px_s2;
	logic [ROW_W-1:0] row_s2;
	logic [CW-1:0]    col_s2;
	logic [CHANNELS-1:0][9:0] cross_s2, corner_s2;

	function automatic logic [PIX_W-1:0] kernel(
		input logic [1:0]       mode,
		input logic [PIX_W-1:0] lim,
		input logic [PIX_W-1:0] centre,
		input logic [9:0]       cross_sum,
		input logic [9:0]       corners
	);
		logic [11:0]        all_p4;
		logic [24:0]        prod;
		logic [11:0]        gsum;
		logic [13:0]        t;
		logic signed [13:0] v;
		logic [PIX_W-1:0]   res;
		all_p4 = 12'(centre) + 12'(cross_sum) + 12'(corners) + 12'd4;
		prod   = 25'(all_p4) * 25'(BOX_RECIP);
		gsum   = 12'({centre, 2'b00}) + 12'({cross_sum, 1'b0}) + 12'(corners) + 12'd8;
		unique case (mode)
			MODE_EDGE:    t = 14'({centre, 3'b000}) - 14'(cross_sum) - 14'(corners);
			MODE_SHARPEN: t = 14'({centre, 2'b00}) + 14'(centre) - 14'(cross_sum);
			MODE_BOX:     t = 14'(prod[24:16]);
			default:      t = 14'(gsum[11:4]);
		endcase
		v = $signed(t);
		if (v < 14'sd0) begin
			res = '0;
		end else if (v > $signed({6'b0, lim})) begin
			res = lim;
		end else begin
			res = v[PIX_W-1:0];
		end
		return res;
	endfunction

	logic [2:0]       rem_s2;
	logic [1:0]       sel_s2;
	pix_t             filt_px_s2, res_px;
	logic [ROW_W-1:0] res_row;
	logic [CW-1:0]    res_col;
	logic             res_fend;

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			filt_px_s2[k] = kernel(mode_q, max_q, centre_s2[k], cross_s2[k], corner_s2[k]);
		end
		// lowest pending result goes first
		if (pend_s2[0]) begin
			sel_s2 = 2'd0;
			rem_s2 = {pend_s2[2:1], 1'b0};
		end else if (pend_s2[1]) begin
			sel_s2 = 2'd1;
			rem_s2 = {pend_s2[2], 2'b00};
		end else begin
			sel_s2 = 2'd2;
			rem_s2 = 3'b000;
		end
		case (sel_s2)
			2'd0: begin
				res_row  = row_s2 - 16'd1;
				res_col  = col_s2 - CW'(1);
				res_px   = filt_s2 ? filt_px_s2 : centre_s2;
				res_fend = 1'b0;
			end
			2'd1: begin
				res_row  = row_s2 - 16'd1;
				res_col  = col_s2;
				res_px   = mid_s2;
				res_fend = 1'b0;
			end
			default: begin
				res_row  = row_s2;
				res_col  = col_s2;
				res_px   = px_s2;
				res_fend = last_col_s2;
			end
		endcase
	end

	assign issue   = s2_valid && out_rdy;
	assign s2_free = !s2_valid || (issue && (rem_s2 == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			pend_s2  <= '0;
		end else if (s1_adv && (emit_s1 != '0)) begin
			s2_valid <= 1'b1;
			pend_s2  <= emit_s1;
		end else if (issue) begin
			pend_s2 <= rem_s2;
			if (rem_s2 == '0) begin
				s2_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && (emit_s1 != '0)) begin
			filt_s2     <= filt_s1;
			last_col_s2 <= last_col_s1;
			centre_s2   <= win_q[4];
			mid_s2      <= mid;
			px_s2       <= px_s1;
			row_s2      <= row_s1;
			col_s2      <= col_s1;
			cross_s2    <= cross_s1;
			corner_s2   <= corner_s1;
		end
	end

	// ---------------- output register ----------------
	logic             out_valid_q, step_end_q, frame_end_q;
	logic [ROW_W-1:0] out_row_q;
	logic [CW-1:0]    out_col_q;
	pix_t             out_px_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_row_q   <= res_row;
			out_col_q   <= res_col;
			out_px_q    <= res_px;
			step_end_q  <= (rem_s2 == '0);
			frame_end_q <= res_fend;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_red   = out_px_q[0];
	assign out_green = out_px_q[1];
	assign out_blue  = out_px_q[2];
	assign step_end  = step_end_q;
	assign frame_end = frame_end_q;

endmodule

@@ rtl/rgbkf_checker.sv @@
// ----------------------------------------------------------------------------
// rgbkf port checker
// watches the result channel of the filter unit over time
// ----------------------------------------------------------------------------
`include "rgb_3x3_kernel_filter_unit_macros.svh"

module rgbkf_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [rgbkf_pkg::ROW_W-1:0]  out_row,
	input logic [$clog2(MAX_WIDTH)-1:0] out_col,
	input logic [rgbkf_pkg::PIX_W-1:0]  out_red,
	input logic [rgbkf_pkg::PIX_W-1:0]  out_green,
	input logic [rgbkf_pkg::PIX_W-1:0]  out_blue,
	input logic                         step_end,
	input logic                         frame_end
);

	// a stalled transaction stays offered
	`RGBKF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// and keeps its payload
	`RGBKF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_row) && $stable(out_col) && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(step_end) && $stable(frame_end))

	// the final pixel of a frame is always the last result of its transaction
	`RGBKF_ASSERT_NOW(a_fend_step, clk, arst_n, out_valid && frame_end, step_end)

	// results of one transaction follow each other without a gap
	`RGBKF_ASSERT_NEXT(a_step_burst, clk, arst_n, out_valid && !step_end, out_valid)

endmodule

bind rgb_3x3_kernel_filter_unit rgbkf_checker #(.MAX_WIDTH(MAX_WIDTH)) u_rgbkf_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// rgb 3x3 kernel filter unit - self-checking testbench
// streams raster frames through the filter under several register
// settings and idle patterns, predicts every emitted pixel (position, value,
// step and frame marks) and checks the output stream against it in order
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbkf_pkg::*;

	localparam int LINE_MAX      = 1024;
	localparam int COL_W         = $clog2(LINE_MAX);
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 100;
	localparam int RANDOM_ITEMS  = 200;
	localparam int TAIL_ITEMS    = 32;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		pix_t             px;
		logic             step_end;
		logic             frame_end;
	} out_pix_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      in_red    = '0;
	logic [PIX_W-1:0]      in_green  = '0;
	logic [PIX_W-1:0]      in_blue   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ROW_W-1:0]      out_row;
	logic [COL_W-1:0]      out_col;
	logic [PIX_W-1:0]      out_red;
	logic [PIX_W-1:0]      out_green;
	logic [PIX_W-1:0]      out_blue;
	logic                  step_end;
	logic                  frame_end;

	// stimulus and expected streams
	pix_t       raster_q [$];
	out_pix_t   awaited_pixels [$];
	idle_mode_t idle_mode  = IDLE_NONE;
	logic       px_taken   = 1'b0;
	bit         hold_armed = 1'b0;
	int         hold_left  = 0;
	int         errors     = 0;

	// predictor state and register copy
	pix_t             line_prev2 [LINE_MAX];
	pix_t             line_prev1 [LINE_MAX];
	pix_t             win_cols [6];
	pix_t             nbhd [9];
	logic [ROW_W-1:0] row_pos;
	logic [COL_W-1:0] col_pos;
	logic [1:0]       mode_r;
	logic [7:0]       max_lvl;
	logic [FW_W-1:0]  frm_w, sel_l, sel_r;
	logic [ROW_W-1:0] frm_h, sel_t, sel_b;

	rgb_3x3_kernel_filter_unit #(
		.MAX_WIDTH(LINE_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.step_end  (step_end),
		.frame_end (frame_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit sender_pause();
		case (idle_mode)
		IDLE_SEND: return $urandom_range(0, 99) < 87;
		IDLE_BOTH: return $urandom_range(0, 99) < 19;
		default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_pause();
		case (idle_mode)
		IDLE_RECV: return $urandom_range(0, 99) < 87;
		IDLE_BOTH: return $urandom_range(0, 99) < 19;
		default:   return 1'b0;
		endcase
	endfunction

	// one channel of the 3x3 kernel over the current neighborhood
	function automatic logic [7:0] kernel_channel(input int k);
		int centre, plus_sum, all_sum, corners, v;
		centre   = int'(nbhd[4][k]);
		plus_sum = int'(nbhd[1][k]) + int'(nbhd[3][k]) + int'(nbhd[5][k]) + int'(nbhd[7][k]);
		all_sum  = plus_sum + centre + int'(nbhd[0][k]) + int'(nbhd[2][k])
			+ int'(nbhd[6][k]) + int'(nbhd[8][k]);
		corners  = all_sum - centre - plus_sum;
		case (mode_r)
		MODE_EDGE:    v = 9 * centre - all_sum;
		MODE_SHARPEN: v = 5 * centre - plus_sum;
		MODE_BOX:     v = (all_sum + 4) / 9;
		default:      v = (4 * centre + 2 * plus_sum + corners + 8) / 16;
		endcase
		if (v < 0)
			v = 0;
		if (v > int'(max_lvl))
			v = int'(max_lvl);
		return 8'(v);
	endfunction

	task automatic queue_result(input int row, input int col, input pix_t px,
		input bit last_of_step, input bit last_of_frame);
		out_pix_t e;
		e.row       = ROW_W'(row);
		e.col       = COL_W'(col);
		e.px        = px;
		e.step_end  = last_of_step;
		e.frame_end = last_of_frame;
		awaited_pixels.push_back(e);
	endtask

	// advance the raster position by one pixel and queue what it releases
	task automatic advance_raster(input pix_t px);
		int   w, h, r, c;
		bit   last_col, last_row, emit_win, emit_col, emit_self;
		pix_t up, mid, res;
		w = (frm_w == 0) ? 1 : int'(frm_w);
		if (w > LINE_MAX)
			w = LINE_MAX;
		h = (frm_h == 0) ? 1 : int'(frm_h);
		r = int'(row_pos);
		c = int'(col_pos);
		last_col  = c + 1 >= w;
		last_row  = r + 1 >= h;
		up        = line_prev2[c];
		mid       = line_prev1[c];
		emit_win  = r >= 1 && c >= 1;
		emit_col  = r >= 1 && last_col;
		emit_self = last_row;

		if (emit_win) begin
			nbhd[0] = win_cols[0]; nbhd[1] = win_cols[3]; nbhd[2] = up;
			nbhd[3] = win_cols[1]; nbhd[4] = win_cols[4]; nbhd[5] = mid;
			nbhd[6] = win_cols[2]; nbhd[7] = win_cols[5]; nbhd[8] = px;
			res = win_cols[4];
			// interior pixel inside the selection gets the kernel
			if (r - 1 > 0 && c - 1 > 0 && r < h && c < w &&
				c - 1 >= int'(sel_l) && c - 1 < int'(sel_r) &&
				r - 1 >= int'(sel_t) && r - 1 < int'(sel_b)) begin
				for (int k = 0; k < CHANNELS; k++)
					res[k] = kernel_channel(k);
			end
			queue_result(r - 1, c - 1, res, !emit_col && !emit_self, 1'b0);
		end
		if (emit_col)
			queue_result(r - 1, c, mid, !emit_self, 1'b0);
		if (emit_self)
			queue_result(r, c, px, 1'b1, last_col);

		line_prev2[c] = mid;
		line_prev1[c] = px;
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = up;
		win_cols[4] = mid;
		win_cols[5] = px;
		if (last_col) begin
			col_pos = '0;
			row_pos = last_row ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	task automatic check_output();
		out_pix_t got, want;
		got.row       = out_row;
		got.col       = out_col;
		got.px        = {out_blue, out_green, out_red};
		got.step_end  = step_end;
		got.frame_end = frame_end;
		if (awaited_pixels.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: unexpected pixel row %0d col %0d bgr %h step %b frame %b",
					$time, got.row, got.col, got.px, got.step_end, got.frame_end);
		end else begin
			want = awaited_pixels.pop_front();
			if (got.row !== want.row || got.col !== want.col || got.px !== want.px ||
				got.step_end !== want.step_end || got.frame_end !== want.frame_end) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: pixel mismatch, expected row %0d col %0d bgr %h step %b frame %b, got row %0d col %0d bgr %h step %b frame %b",
						$time, want.row, want.col, want.px, want.step_end, want.frame_end,
						got.row, got.col, got.px, got.step_end, got.frame_end);
			end
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk) begin
		px_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			advance_raster(raster_q.pop_front());
		if (arst_n && out_valid && !out_stall)
			check_output();
	end

	// input driver: a new transaction is offered only once the last one went through
	always @(negedge clk) begin
		pix_t head;
		if (!in_valid || px_taken) begin
			if (raster_q.size() != 0 && !sender_pause()) begin
				head = raster_q[0];
				in_valid <= 1'b1;
				in_red   <= head[0];
				in_green <= head[1];
				in_blue  <= head[2];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall, with one long hold-off to back the block up to its input
	always @(negedge clk) begin
		if (hold_armed) begin
			hold_armed = 1'b0;
			hold_left  = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left  = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= receiver_pause();
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		case (idx)
		REG_FILTER_MODE:  mode_r  = val[1:0];
		REG_MAX_LEVEL:    max_lvl = val[7:0];
		REG_FRAME_WIDTH:  frm_w   = val[FW_W-1:0];
		REG_FRAME_HEIGHT: frm_h   = val[ROW_W-1:0];
		REG_SEL_LEFT:     sel_l   = val[FW_W-1:0];
		REG_SEL_TOP:      sel_t   = val[ROW_W-1:0];
		REG_SEL_RIGHT:    sel_r   = val[FW_W-1:0];
		default:          sel_b   = val[ROW_W-1:0];
		endcase
	endtask

	task automatic configure(input logic [1:0] mode, input int lvl, input int w, input int h,
		input int sl, input int st, input int sr, input int sb);
		write_reg(REG_FILTER_MODE, mode);
		write_reg(REG_MAX_LEVEL, lvl);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_SEL_LEFT, sl);
		write_reg(REG_SEL_TOP, st);
		write_reg(REG_SEL_RIGHT, sr);
		write_reg(REG_SEL_BOTTOM, sb);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_random(input int count, input bit saturating);
		pix_t px;
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < CHANNELS; k++)
				px[k] = (!saturating || $urandom_range(0, 1)) ? 8'($urandom_range(0, 255)) :
					($urandom_range(0, 1) ? 8'hFF : 8'h00);
			raster_q.push_back(px);
		end
	endtask

	// wait for every pixel to be sent and every result to come back
	task automatic drain();
		while (raster_q.size() != 0 || in_valid || awaited_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// 3x3 frame with one filtered pixel in the middle
	task automatic directed_frame(input logic [1:0] mode, input int lvl,
		input pix_t centre, input pix_t around);
		configure(mode, lvl, 3, 3, 0, 0, LINE_MAX, 65535);
		idle_mode = IDLE_NONE;
		for (int i = 0; i < 9; i++)
			raster_q.push_back(i == 4 ? centre : around);
		drain();
	endtask

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int rand_items, ph, w, h, w_eff, h_eff, sel_kind, lvl;
		int sl, st, sr, sb;

		foreach (line_prev2[i]) begin
			line_prev2[i] = '0;
			line_prev1[i] = '0;
		end
		foreach (win_cols[i])
			win_cols[i] = '0;
		row_pos = '0;
		col_pos = '0;
		mode_r  = MODE_EDGE;
		max_lvl = 8'd255;
		frm_w   = FW_W'(LINE_MAX);
		frm_h   = 16'd1;
		sel_l   = '0;
		sel_t   = '0;
		sel_r   = FW_W'(LINE_MAX);
		sel_b   = 16'hFFFF;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: each kernel, clamping at both ends, zero clamp limit
		directed_frame(MODE_EDGE, 255, {8'hFF, 8'h80, 8'h00}, {8'h00, 8'h7F, 8'hFF});
		directed_frame(MODE_SHARPEN, 255, {8'h00, 8'hFF, 8'h40}, {8'hFF, 8'h00, 8'h10});
		directed_frame(MODE_BOX, 200, {8'hFF, 8'hFF, 8'h00}, {8'hFF, 8'h01, 8'hFF});
		directed_frame(MODE_GAUSS, 0, {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF});

		// random frames, idle pattern rotating per frame
		rand_items = 0;
		ph = 0;
		while (rand_items < RANDOM_ITEMS || ph <= 4) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
			if (ph == 4) begin
				w = 10;
				h = 6;
			end
			w_eff = (w == 0) ? 1 : w;
			h_eff = (h == 0) ? 1 : h;
			lvl = (ph == 0) ? 1 : (ph == 1) ? 255 : $urandom_range(1, 255);
			sel_kind = (ph == 0) ? 2 : (ph == 1) ? 0 : $urandom_range(0, 3);
			case (sel_kind)
			0: begin
				sl = 0; st = 0; sr = LINE_MAX; sb = 65535;
			end
			2: begin
				// empty selection: left at the line length, top at its maximum, right and bottom zero
				sl = LINE_MAX; st = 65535; sr = 0; sb = 0;
			end
			default: begin
				sl = $urandom_range(0, w_eff);
				sr = $urandom_range(0, w_eff + 1);
				st = $urandom_range(0, h_eff);
				sb = $urandom_range(0, h_eff + 1);
			end
			endcase
			configure(2'($urandom_range(0, 3)), lvl, w, h, sl, st, sr, sb);
			idle_mode = idle_mode_t'(ph % 4);
			if (ph == 4)
				hold_armed = 1'b1;
			push_random(w_eff * h_eff, $urandom_range(0, 1));
			drain();
			rand_items += w_eff * h_eff;
			ph++;
		end

		// width above the line length saturates; a single-row frame, first pixels only
		idle_mode = IDLE_NONE;
		configure(MODE_BOX, 128, 2047, 0, LINE_MAX, 65535, 0, 0);
		push_random(TAIL_ITEMS, 1'b0);
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
